[sv/wcri_pkg.sv]
package wcri_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  // entry_index is 8 bits, so at most this many entries can ever be written
  localparam int ENTRY_CAP = 256;
  localparam int ONE_Q16 = 65536;
  localparam int CFG_W = 21;

  localparam logic [15:0] DENSITY_RST = 16'd256;
  localparam logic signed [20:0] OFFSET_RST = 21'sd0;
  localparam logic REPEAT_RST = 1'b1;

  typedef enum logic [1:0] {
    REG_DENSITY = 2'd0,
    REG_OFFSET  = 2'd1,
    REG_REPEAT  = 2'd2
  } reg_idx_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] position;
    logic [7:0]  entry_index;
    logic [7:0]  entry_red;
    logic [7:0]  entry_green;
    logic [7:0]  entry_blue;
  } item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

endpackage

[sv/wcri_chan_if.sv]
interface wcri_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/wcri_ram.sv]
module wcri_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/wrapping_color_ramp_interpolator.sv]
// Lookup words pass the input, wrap, split, read and blend registers to result.
// Throughput: one word per cycle, writes and lookups alike, unless result stalls;
// a table write is committed in stage 4 in order with lookups and yields no result word.
// Reset (rst, synchronous): empties the pipeline, loads the config registers
// with their defaults and clears the per-entry valid bits, so all entries
// read as zero right after reset. No clearing pass is needed.
module wrapping_color_ramp_interpolator #(
  parameter int TABLE_DEPTH = wcri_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  wcri_chan_if.sink                  item,
  wcri_chan_if.source                result,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_addr,
  input  logic [wcri_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int SW = 17 + IW;
  localparam int MEM_DEPTH =
    (TABLE_DEPTH < wcri_pkg::ENTRY_CAP) ? TABLE_DEPTH : wcri_pkg::ENTRY_CAP;
  localparam int MAW = $clog2(MEM_DEPTH);
  localparam int CW = $bits(wcri_pkg::color_t);
  localparam logic [IW:0] DEPTH_W = (IW + 1)'(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST_I = IW'(TABLE_DEPTH - 1);
  localparam logic signed [25:0] X_ONE = 26'(wcri_pkg::ONE_Q16);

  // config
  logic [15:0]        density;
  logic signed [20:0] offset;
  logic               repeat_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      density    <= wcri_pkg::DENSITY_RST;
      offset     <= wcri_pkg::OFFSET_RST;
      repeat_cfg <= wcri_pkg::REPEAT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        wcri_pkg::REG_DENSITY: density <= cfg_wdata[15:0];
        wcri_pkg::REG_OFFSET:  offset <= signed'(cfg_wdata[20:0]);
        wcri_pkg::REG_REPEAT:  repeat_cfg <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pipeline handshake: each stage moves when the next has room
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5 || result.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign item.ready = en1;

  wcri_pkg::item_t d1, d2, d3;
  logic [31:0] prod1;
  logic [16:0] xs2, xs_next;
  logic [IW-1:0] i3, j3, i_next, j_next;
  logic [15:0] f3, f4;
  logic ok_i4, ok_j4;
  logic [CW-1:0] q_i, q_j;
  wcri_pkg::color_t out5, out_next;

  logic signed [25:0] x_raw, x_clamp;
  logic [SW-1:0] s_scaled;
  logic [IW:0] i_full;
  logic ram_we, ram_re;
  logic [MAW-1:0] ai, aj;
  logic beyond_i, beyond_j;
  logic [MEM_DEPTH-1:0] ent_vld;
  wcri_pkg::color_t lo_c, hi_c;

  // stage 2: scale, offset, clamp or wrap into [0,1]
  always_comb begin
    x_raw = $signed({2'b00, prod1[31:8]}) + 26'(offset);
    x_clamp = (!repeat_cfg && x_raw > X_ONE) ? X_ONE : x_raw;
    if (x_clamp > X_ONE || x_clamp < 0) begin
      xs_next = {1'b0, x_clamp[15:0]};
    end else begin
      xs_next = x_clamp[16:0];
    end
  end

  // stage 3: split scaled position into entry pair and fraction
  always_comb begin
    s_scaled = SW'(xs2) * SW'(TABLE_DEPTH);
    i_full = s_scaled[SW-1:16];
    i_next = (i_full >= DEPTH_W) ? '0 : i_full[IW-1:0];
    j_next = (i_next == LAST_I) ? '0 : i_next + IW'(1);
  end

  // stage 4 addressing; entries past the writable range always read zero
  assign ai = i3[MAW-1:0];
  assign aj = j3[MAW-1:0];
  assign beyond_i = 32'(i3) >= MEM_DEPTH;
  assign beyond_j = 32'(j3) >= MEM_DEPTH;
  assign ram_we = en4 && v3 && (d3.operation == wcri_pkg::OP_WRITE)
                  && (32'(d3.entry_index) < TABLE_DEPTH);
  assign ram_re = en4;

  wcri_ram #(.WIDTH(CW), .DEPTH(MEM_DEPTH)) u_ram_lo (
    .clk   (clk),
    .we    (ram_we),
    .waddr (d3.entry_index[MAW-1:0]),
    .wdata ({d3.entry_red, d3.entry_green, d3.entry_blue}),
    .re    (ram_re),
    .raddr (ai),
    .rdata (q_i)
  );

  wcri_ram #(.WIDTH(CW), .DEPTH(MEM_DEPTH)) u_ram_hi (
    .clk   (clk),
    .we    (ram_we),
    .waddr (d3.entry_index[MAW-1:0]),
    .wdata ({d3.entry_red, d3.entry_green, d3.entry_blue}),
    .re    (ram_re),
    .raddr (aj),
    .rdata (q_j)
  );

  // stage 5: blend
  function automatic logic [7:0] blend(input logic [7:0] lo, input logic [7:0] hi,
                                       input logic [15:0] f);
    logic signed [8:0]  d;
    logic signed [25:0] acc;
    d = $signed({1'b0, hi}) - $signed({1'b0, lo});
    acc = $signed({2'b00, lo, 16'h0000}) + $signed({1'b0, f}) * d;
    return acc[23:16];
  endfunction

  always_comb begin
    lo_c = ok_i4 ? wcri_pkg::color_t'(q_i) : '0;
    hi_c = ok_j4 ? wcri_pkg::color_t'(q_j) : '0;
    out_next.red   = blend(lo_c.red, hi_c.red, f4);
    out_next.green = blend(lo_c.green, hi_c.green, f4);
    out_next.blue  = blend(lo_c.blue, hi_c.blue, f4);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      ent_vld <= '0;
    end else begin
      if (en1) v1 <= item.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      // write words retire here
      if (en4) v4 <= v3 && (d3.operation == wcri_pkg::OP_LOOKUP);
      if (en5) v5 <= v4;
      if (ram_we) ent_vld[d3.entry_index[MAW-1:0]] <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en1) begin
      d1    <= item.data;
      prod1 <= item.data.position * density;
    end
    if (en2) begin
      d2  <= d1;
      xs2 <= xs_next;
    end
    if (en3) begin
      d3 <= d2;
      i3 <= i_next;
      j3 <= j_next;
      f3 <= s_scaled[15:0];
    end
    if (en4) begin
      f4    <= f3;
      ok_i4 <= !beyond_i && ent_vld[ai];
      ok_j4 <= !beyond_j && ent_vld[aj];
    end
    if (en5) begin
      out5 <= out_next;
    end
  end

  assign result.valid = v5;
  assign result.data  = out5;

  // a table write never reaches the blend stage
  assert property (@(posedge clk) disable iff (rst) ram_we |=> !v4)
    else $error("write word entered the blend stage");

  // a lookup held in stage 4 keeps its read data context
  assert property (@(posedge clk) disable iff (rst)
    v4 && !en4 |=> v4 && $stable(f4) && $stable(q_i) && $stable(q_j))
    else $error("stalled lookup lost its read data");

  assert property (@(posedge clk) disable iff (rst) v3 |-> i3 <= LAST_I)
    else $error("entry index past table depth");

  assert property (@(posedge clk) disable iff (rst)
    v3 |-> (j3 == i3 + IW'(1)) || (j3 == '0 && i3 == LAST_I))
    else $error("successor entry is not the cyclic next one");

endmodule

[verif/tb_wrapping_color_ramp_interpolator.sv]
module tb_wrapping_color_ramp_interpolator;
  import wcri_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  // pipeline is 5 deep; a few spare cycles before touching config
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 125;

  typedef struct {
    bit          is_cfg;
    reg_idx_t    reg_sel;
    logic [20:0] reg_val;
    item_t       word;
    bit          typed;
    color_t      known;
  } plan_row_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_addr;
  logic [CFG_W-1:0]   cfg_wdata;

  wcri_chan_if #(.T(item_t))  item_ch ();
  wcri_chan_if #(.T(color_t)) result_ch ();

  wrapping_color_ramp_interpolator DUT (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the block's state
  logic [7:0]         ramp_r [DEPTH];
  logic [7:0]         ramp_g [DEPTH];
  logic [7:0]         ramp_b [DEPTH];
  logic [15:0]        density_q;
  logic signed [20:0] offset_q;
  logic               repeat_q;

  color_t             pending_colors [$];
  int                 mismatches;
  bit                 steady_flow;
  plan_row_t          directed_plan [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [7:0] blend(input logic [7:0] lo, input logic [7:0] hi,
                                       input longint frac);
    longint acc;
    acc = longint'(lo) * 65536 + frac * (longint'(hi) - longint'(lo));
    if (acc < 0) acc = 0;
    return 8'(acc >> 16);
  endfunction

  function automatic color_t ramp_color(input logic [15:0] pos);
    longint x;
    longint xs;
    longint scaled;
    longint lo_idx;
    longint hi_idx;
    longint frac;
    color_t c;
    x = ((longint'(pos) * longint'(density_q)) >> 8) + longint'(offset_q);
    if (!repeat_q && x > ONE_Q16) x = ONE_Q16;
    if (x > ONE_Q16 || x < 0) xs = x & 64'hFFFF;
    else xs = x;
    scaled = xs * DEPTH;
    lo_idx = scaled >> 16;
    frac = scaled & 64'hFFFF;
    // x == 1.0 lands one past the end and wraps to entry 0
    if (lo_idx >= DEPTH) lo_idx = 0;
    hi_idx = (lo_idx + 1 >= DEPTH) ? 0 : lo_idx + 1;
    c.red   = blend(ramp_r[lo_idx], ramp_r[hi_idx], frac);
    c.green = blend(ramp_g[lo_idx], ramp_g[hi_idx], frac);
    c.blue  = blend(ramp_b[lo_idx], ramp_b[hi_idx], frac);
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic plan_row_t write_row(input logic [7:0] idx, input logic [7:0] r,
                                          input logic [7:0] g, input logic [7:0] b);
    plan_row_t row;
    row = '{reg_sel: REG_DENSITY, default: '0};
    row.word.operation   = OP_WRITE;
    row.word.position    = 16'($urandom);
    row.word.entry_index = idx;
    row.word.entry_red   = r;
    row.word.entry_green = g;
    row.word.entry_blue  = b;
    return row;
  endfunction

  function automatic plan_row_t lookup_row(input logic [15:0] pos, input bit typed,
                                           input color_t known);
    plan_row_t row;
    row = '{reg_sel: REG_DENSITY, default: '0};
    row.word.operation   = OP_LOOKUP;
    row.word.position    = pos;
    row.word.entry_index = 8'($urandom);
    row.word.entry_red   = 8'($urandom);
    row.word.entry_green = 8'($urandom);
    row.word.entry_blue  = 8'($urandom);
    row.typed = typed;
    row.known = known;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input reg_idx_t sel, input logic [20:0] val);
    plan_row_t row;
    row = '{reg_sel: REG_DENSITY, default: '0};
    row.is_cfg  = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    return row;
  endfunction

  function automatic item_t rand_word();
    item_t w;
    int r;
    w.operation = ($urandom_range(0, 99) < 60) ? OP_LOOKUP : OP_WRITE;
    r = $urandom_range(0, 9);
    if (r == 0) w.position = 16'h0000;
    else if (r == 1) w.position = 16'hFFFF;
    else w.position = 16'($urandom);
    w.entry_index = 8'($urandom);
    w.entry_red   = 8'($urandom);
    w.entry_green = 8'($urandom);
    w.entry_blue  = 8'($urandom);
    return w;
  endfunction

  // drive one word, wait for the handshake, then update the shadow state
  task automatic push_word(input item_t w, input bit typed, input color_t known);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= w;
    do @(posedge clk); while (!item_ch.ready);
    if (w.operation == OP_LOOKUP) begin
      pending_colors.push_back(typed ? known : ramp_color(w.position));
    end else if (int'(w.entry_index) < DEPTH) begin
      ramp_r[w.entry_index] = w.entry_red;
      ramp_g[w.entry_index] = w.entry_green;
      ramp_b[w.entry_index] = w.entry_blue;
    end
  endtask

  // config only changes with the pipeline empty
  task automatic write_reg(input reg_idx_t sel, input logic [20:0] val);
    item_ch.valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (sel)
      REG_DENSITY: density_q = val[15:0];
      REG_OFFSET:  offset_q  = val;
      REG_REPEAT:  repeat_q  = val[0];
      default: ;
    endcase
  endtask

  // result side: random back-pressure and in-order compare
  initial begin
    int stall_left;
    int r;
    color_t exp_c;
    stall_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        if (pending_colors.size() == 0) begin
          $error("unexpected color word %h", result_ch.data);
          mismatches++;
        end else begin
          exp_c = pending_colors.pop_front();
          if (result_ch.data.red !== exp_c.red) begin
            $error("red: expected %0d, got %0d", exp_c.red, result_ch.data.red);
            mismatches++;
          end
          if (result_ch.data.green !== exp_c.green) begin
            $error("green: expected %0d, got %0d", exp_c.green, result_ch.data.green);
            mismatches++;
          end
          if (result_ch.data.blue !== exp_c.blue) begin
            $error("blue: expected %0d, got %0d", exp_c.blue, result_ch.data.blue);
            mismatches++;
          end
        end
      end
      if (steady_flow) begin
        stall_left = 0;
        result_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        r = $urandom_range(0, 99);
        if (r < 20) stall_left = $urandom_range(1, 3);
        else if (r < 23) stall_left = $urandom_range(10, 40);
      end
    end
  end

  initial begin
    color_t black;
    color_t c_e0;
    color_t c_e1;
    color_t white;
    logic [15:0] dens;
    logic [20:0] offs;
    black = '{8'h00, 8'h00, 8'h00};
    c_e0  = '{8'hFF, 8'h00, 8'h80};
    c_e1  = '{8'h10, 8'h20, 8'h30};
    white = '{8'hFF, 8'hFF, 8'hFF};

    mismatches  = 0;
    steady_flow = 1'b0;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    for (int k = 0; k < DEPTH; k++) begin
      ramp_r[k] = '0;
      ramp_g[k] = '0;
      ramp_b[k] = '0;
    end
    density_q = DENSITY_RST;
    offset_q  = OFFSET_RST;
    repeat_q  = REPEAT_RST;

    // table starts cleared
    directed_plan.push_back(lookup_row(16'h0000, 1'b1, black));
    directed_plan.push_back(lookup_row(16'hFFFF, 1'b1, black));
    directed_plan.push_back(write_row(8'd0,   8'hFF, 8'h00, 8'h80));
    directed_plan.push_back(write_row(8'd255, 8'h00, 8'hFF, 8'h7F));
    directed_plan.push_back(write_row(8'd1,   8'h10, 8'h20, 8'h30));
    directed_plan.push_back(lookup_row(16'h0000, 1'b1, c_e0));
    // last entry blends into entry 0
    directed_plan.push_back(lookup_row(16'hFFFF, 1'b0, black));
    directed_plan.push_back(lookup_row(16'h0100, 1'b1, c_e1));
    directed_plan.push_back(lookup_row(16'h0080, 1'b0, black));
    directed_plan.push_back(write_row(8'd128, 8'hFF, 8'hFF, 8'hFF));
    directed_plan.push_back(lookup_row(16'h8000, 1'b1, white));
    directed_plan.push_back(write_row(8'd254, 8'h01, 8'h02, 8'h03));
    directed_plan.push_back(lookup_row(16'hFE80, 1'b0, black));
    // clamp to exactly one -> entry 0
    directed_plan.push_back(cfg_row(REG_DENSITY, 21'd512));
    directed_plan.push_back(cfg_row(REG_REPEAT, 21'd0));
    directed_plan.push_back(lookup_row(16'h8000, 1'b1, c_e0));
    directed_plan.push_back(lookup_row(16'hFFFF, 1'b1, c_e0));
    directed_plan.push_back(cfg_row(REG_REPEAT, 21'd1));
    directed_plan.push_back(lookup_row(16'h8000, 1'b1, c_e0));
    directed_plan.push_back(lookup_row(16'hC000, 1'b1, white));
    // negative offset wraps from below
    directed_plan.push_back(cfg_row(REG_DENSITY, 21'd256));
    directed_plan.push_back(cfg_row(REG_OFFSET, 21'h1FC000));
    directed_plan.push_back(lookup_row(16'h0000, 1'b0, black));
    directed_plan.push_back(lookup_row(16'h4000, 1'b1, c_e0));
    directed_plan.push_back(cfg_row(REG_DENSITY, 21'd0));
    directed_plan.push_back(cfg_row(REG_OFFSET, 21'h0FFFFF));
    directed_plan.push_back(lookup_row(16'h1234, 1'b0, black));
    directed_plan.push_back(cfg_row(REG_DENSITY, 21'hFFFF));
    directed_plan.push_back(cfg_row(REG_OFFSET, 21'h100000));
    directed_plan.push_back(lookup_row(16'hFFFF, 1'b0, black));
    directed_plan.push_back(lookup_row(16'h0000, 1'b0, black));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[n]) begin
      if (directed_plan[n].is_cfg)
        write_reg(directed_plan[n].reg_sel, directed_plan[n].reg_val);
      else
        push_word(directed_plan[n].word, directed_plan[n].typed, directed_plan[n].known);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        dens = 16'h0000;
        offs = 21'h100000;
      end else if (ph == 1) begin
        dens = 16'hFFFF;
        offs = 21'h0FFFFF;
      end else begin
        case ($urandom_range(0, 3))
          0: dens = 16'd256;
          1: dens = 16'd512;
          2: dens = 16'($urandom_range(0, 1023));
          default: dens = 16'($urandom);
        endcase
        case ($urandom_range(0, 2))
          0: offs = '0;
          1: offs = 21'($urandom_range(0, 262143) - 131072);
          default: offs = 21'($urandom);
        endcase
      end
      write_reg(REG_DENSITY, 21'(dens));
      write_reg(REG_OFFSET, offs);
      write_reg(REG_REPEAT, 21'(ph == 0 ? 0 : (ph == 1 ? 1 : $urandom_range(0, 1))));
      steady_flow = (ph % 3 == 2);
      for (int n = 0; n < WORDS_PER_PHASE; n++)
        push_word(rand_word(), 1'b0, black);
      steady_flow = 1'b0;
    end

    item_ch.valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
sv/wcri_pkg.sv
sv/wcri_chan_if.sv
sv/wcri_ram.sv
sv/wrapping_color_ramp_interpolator.sv
verif/tb_wrapping_color_ramp_interpolator.sv
